// ----- design/aotr_pkg.sv -----
// shared constants, types and command/status structs of the or/xor reduction tree
// no dependencies
package aotr_pkg;

  localparam int MAX_LEVELS = 10;
  localparam int VALUE_BITS = 32;
  localparam int NODE_AW    = MAX_LEVELS + 1;
  localparam int NODE_COUNT = 2 ** NODE_AW;
  localparam int HEIGHT_W   = $clog2(MAX_LEVELS + 1);
  localparam int IDX_W      = 10;
  localparam int ROOT_W     = 32;
  localparam int LVL_W      = 4;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;

  localparam logic [CFG_AW-1:0] REG_LEVELS_IN_USE = CFG_AW'(0);
  localparam logic [LVL_W-1:0]  LEVELS_RESET      = LVL_W'(10);

  typedef logic [NODE_AW-1:0]    node_addr_t;
  typedef logic [VALUE_BITS-1:0] node_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_ROOT  = 4'b1000
  } aotr_state_t;

  typedef struct packed {
    logic clear;     // write zero at the sweep address
    logic load;      // write the leaf, read its sibling
    logic step;      // combine, write the parent, read the next sibling
    logic root_rd;   // read the root for a rejected word
    logic fin_walk;  // capture the new root as the result
    logic fin_err;   // capture the stored root as the result, flag set
  } aotr_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic in_range;
    logic at_top;
  } aotr_status_t;

endpackage

// ----- design/aotr_ctrl.sv -----
// controller state machine: store clearing sweep, leaf-to-root walk, result strobe
// depends on aotr_pkg
module aotr_ctrl import aotr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  aotr_status_t status,
  output aotr_cmd_t    cmd,
  output logic         busy,
  output logic         out_valid
);

  aotr_state_t state_r, state_nxt;
  logic        valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (status.in_range) begin
            cmd.load  = 1'b1;
            state_nxt = ST_WALK;
          end else begin
            cmd.root_rd = 1'b1;
            state_nxt   = ST_ROOT;
          end
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (status.at_top) begin
          cmd.fin_walk = 1'b1;
          valid_nxt    = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_ROOT: begin
        cmd.fin_err = 1'b1;
        valid_nxt   = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

endmodule

// ----- design/aotr_dp.sv -----
// datapath: heap-ordered node store, path walk registers, or/xor combine, result registers
// depends on aotr_pkg
module aotr_dp import aotr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  aotr_cmd_t           cmd,
  input  logic [HEIGHT_W-1:0] height,
  input  logic [IDX_W-1:0]    in_leaf_index,
  input  logic [31:0]         in_leaf_value,
  output aotr_status_t        status,
  output logic [ROOT_W-1:0]   out_root_value,
  output logic                out_index_error
);

  node_word_t mem [NODE_COUNT];

  node_addr_t clr_cnt_r, clr_cnt_nxt;
  node_addr_t node_r, node_nxt;
  node_word_t cur_r, cur_nxt;
  logic       odd_r, odd_nxt;   // parity of the level being computed
  node_word_t rdata_r;

  node_addr_t leaf_addr;
  node_addr_t parent;
  node_word_t combined;
  logic       wr_en;
  node_addr_t wr_addr;
  node_word_t wr_data;
  logic       rd_en;
  node_addr_t rd_addr;

  logic [ROOT_W-1:0] root_r;
  logic              err_r;

  assign leaf_addr = (node_addr_t'(1) << height) | node_addr_t'(in_leaf_index);
  assign parent    = node_r >> 1;
  assign combined  = odd_r ? (cur_r | rdata_r) : (cur_r ^ rdata_r);

  assign status.clear_done = (clr_cnt_r == node_addr_t'(NODE_COUNT - 1));
  assign status.in_range   = (node_addr_t'(in_leaf_index) < (node_addr_t'(1) << height));
  assign status.at_top     = (parent == node_addr_t'(1));

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    node_nxt    = node_r;
    cur_nxt     = cur_r;
    odd_nxt     = odd_r;
    wr_en       = 1'b0;
    wr_addr     = clr_cnt_r;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = node_addr_t'(1);
    if (cmd.clear) begin
      wr_en       = 1'b1;
      clr_cnt_nxt = clr_cnt_r + node_addr_t'(1);
    end
    if (cmd.load) begin
      wr_en    = 1'b1;
      wr_addr  = leaf_addr;
      wr_data  = VALUE_BITS'(in_leaf_value);
      rd_en    = 1'b1;
      rd_addr  = leaf_addr ^ node_addr_t'(1);
      node_nxt = leaf_addr;
      cur_nxt  = VALUE_BITS'(in_leaf_value);
      odd_nxt  = 1'b1;
    end
    if (cmd.step) begin
      wr_en    = 1'b1;
      wr_addr  = parent;
      wr_data  = combined;
      rd_en    = 1'b1;
      rd_addr  = parent ^ node_addr_t'(1);
      node_nxt = parent;
      cur_nxt  = combined;
      odd_nxt  = ~odd_r;
    end
    if (cmd.root_rd) begin
      rd_en   = 1'b1;
      rd_addr = node_addr_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    cur_r  <= cur_nxt;
    odd_r  <= odd_nxt;
    if (cmd.fin_walk) begin
      root_r <= ROOT_W'(combined);
      err_r  <= 1'b0;
    end else if (cmd.fin_err) begin
      root_r <= ROOT_W'(rdata_r);
      err_r  <= 1'b1;
    end
  end

  assign out_root_value  = root_r;
  assign out_index_error = err_r;

endmodule

// ----- design/alternating_or_xor_reduction_tree.sv -----
// a valid leaf write walks from the leaf to the root, one level per cycle, then strobes its result (L = height);
// an out-of-range index reads the stored root and strobes it; busy stays high while the walk or root read runs
// a new word is accepted only while busy is low, so the block takes no new word until the last one is through
// reset: rst_n clears all 2048 words of the store in a sweep with busy high; height resets to 10
// results cannot be stalled: out_valid is a one-cycle strobe
// depends on aotr_pkg, aotr_ctrl, aotr_dp
module alternating_or_xor_reduction_tree import aotr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [IDX_W-1:0]  in_leaf_index,
  input  logic [31:0]       in_leaf_value,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root_value,
  output logic              out_index_error,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [LVL_W-1:0]    levels_r, levels_nxt;
  logic [HEIGHT_W-1:0] height;
  aotr_cmd_t           cmd;
  aotr_status_t        status;

  assign pready = 1'b1;

  always_comb begin
    levels_nxt = levels_r;
    if (psel && penable && pwrite && (paddr == REG_LEVELS_IN_USE)) begin
      levels_nxt = pwdata[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LEVELS_RESET;
    end else begin
      levels_r <= levels_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_LEVELS_IN_USE) begin
      prdata = CFG_DW'(levels_r);
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (levels_r == '0) begin
      height = HEIGHT_W'(1);
    end else if (32'(levels_r) > MAX_LEVELS) begin
      height = HEIGHT_W'(MAX_LEVELS);
    end else begin
      height = HEIGHT_W'(levels_r);
    end
  end

  aotr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  aotr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .height          (height),
    .in_leaf_index   (in_leaf_index),
    .in_leaf_value   (in_leaf_value),
    .status          (status),
    .out_root_value  (out_root_value),
    .out_index_error (out_index_error)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for alternating_or_xor_reduction_tree: leaf writes in, root words out
// scoreboard class keeps its own copy of the node store; depends on aotr_pkg and the block rtl
module tb_top import aotr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ROOT_W-1:0] root;
    logic              err;
  } root_result_t;

  class root_scoreboard;
    node_word_t       node_store [NODE_COUNT];
    logic [LVL_W-1:0] height_reg;
    root_result_t     pending [$];
    int unsigned      fails;

    function new();
      foreach (node_store[i]) node_store[i] = '0;
      height_reg = LEVELS_RESET;
      fails = 0;
    endfunction

    function void set_height(logic [LVL_W-1:0] value);
      height_reg = value;
    endfunction

    // zero acts as one, anything above the maximum acts as the maximum
    function int unsigned active_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_LEVELS) return MAX_LEVELS;
      return height_reg;
    endfunction

    function void note_word(logic [IDX_W-1:0] idx, logic [31:0] value);
      int unsigned  leaves;
      int unsigned  node;
      int unsigned  lvl;
      logic         err;
      root_result_t exp_r;
      leaves = 1 << active_height();
      err = (idx >= leaves);
      if (!err) begin
        node = leaves + idx;
        node_store[node] = value;
        lvl = 0;
        // odd levels above the leaves take or, even levels take xor
        while (node > 1) begin
          node = node >> 1;
          lvl++;
          if (lvl % 2 == 1)
            node_store[node] = node_store[2*node] | node_store[2*node+1];
          else
            node_store[node] = node_store[2*node] ^ node_store[2*node+1];
        end
      end
      exp_r.root = node_store[1][ROOT_W-1:0];
      exp_r.err  = err;
      pending.push_back(exp_r);
    endfunction

    function void check_root(logic [ROOT_W-1:0] root, logic err);
      root_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no word outstanding: root_value %h index_error %b", root, err);
        fails++;
        return;
      end
      exp_r = pending.pop_front();
      if (root !== exp_r.root) begin
        $error("root_value: expected %h, got %h", exp_r.root, root);
        fails++;
      end
      if (err !== exp_r.err) begin
        $error("index_error: expected %b, got %b", exp_r.err, err);
        fails++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [IDX_W-1:0]  in_leaf_index;
  logic [31:0]       in_leaf_value;
  logic              out_valid;
  logic [ROOT_W-1:0] out_root_value;
  logic              out_index_error;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  root_scoreboard sb;
  bit             gaps_on;

  alternating_or_xor_reduction_tree uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_leaf_index   (in_leaf_index),
    .in_leaf_value   (in_leaf_value),
    .out_valid       (out_valid),
    .out_root_value  (out_root_value),
    .out_index_error (out_index_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_root(out_root_value, out_index_error);
  end

  task automatic send_word(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    while (gaps_on && $urandom_range(0, 99) < 23) begin
      start = 1'b0;
      @(negedge clk);
    end
    start         = 1'b1;
    in_leaf_index = idx;
    in_leaf_value = value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(idx, value);
    @(negedge clk);
  endtask

  // hold the sender off until every outstanding word has its result
  task automatic drain_results();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_height(input logic [LVL_W-1:0] height);
    drain_results();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_AW'(4 * REG_LEVELS_IN_USE);
    // upper bits are random, only the low nibble is kept
    pwdata  = {(CFG_DW-LVL_W)'($urandom()), height};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_height(height);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(input logic [LVL_W-1:0] height, input int unsigned count);
    int unsigned leaves;
    int unsigned n;
    int unsigned idx;
    write_height(height);
    leaves = 1 << sb.active_height();
    n = 0;
    // small shapes get every leaf rewritten first so the root is consistent again
    if (leaves <= 32) begin
      for (idx = 0; idx < leaves; idx++) begin
        send_word(IDX_W'(idx), pick_value());
        n++;
      end
    end
    while (n < count) begin
      if (n == count / 2) drain_results();
      if ($urandom_range(0, 99) < 85) idx = $urandom_range(0, leaves - 1);
      else idx = $urandom_range(0, 1023);
      send_word(IDX_W'(idx), pick_value());
      n++;
    end
  endtask

  initial begin
    sb            = new();
    gaps_on       = 1'b1;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_leaf_index = '0;
    in_leaf_value = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // store clear sweep runs with busy high
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);

    // full height out of reset
    send_word(10'd0, 32'hFFFF_FFFF);
    send_word(10'd1023, 32'hFFFF_FFFF);
    send_word(10'd1, 32'h1234_5678);
    send_word(10'd512, 32'hA5A5_A5A5);
    send_word(10'd1023, 32'h0);
    send_word(10'd0, 32'h0);
    send_word(10'd511, 32'h8000_0000);
    send_word(10'd1, 32'h0);
    // two leaves, out-of-range indexes rejected
    write_height(4'd1);
    send_word(10'd0, 32'h1);
    send_word(10'd1, 32'h2);
    send_word(10'd2, 32'hFF);
    send_word(10'd1023, 32'h5555_5555);
    // zero height acts as one
    write_height(4'd0);
    send_word(10'd1, 32'hFFFF_FFFF);
    send_word(10'd3, 32'h5);
    // oversize height acts as the maximum, stale words reused
    write_height(4'd15);
    send_word(10'd1023, 32'h0F0F_0F0F);
    send_word(10'd0, 32'hF0F0_F0F0);
    write_height(4'd2);
    send_word(10'd0, 32'h0000_00FF);
    send_word(10'd1, 32'h0000_FF00);
    send_word(10'd2, 32'h00FF_0000);
    send_word(10'd3, 32'hFF00_0000);
    send_word(10'd4, 32'h1);

    // long stretch with no gaps at full height
    gaps_on = 1'b0;
    run_phase(4'd10, 80);
    gaps_on = 1'b1;
    run_phase(4'd1, 80);
    run_phase(4'd3, 80);
    run_phase(4'd0, 80);
    run_phase(4'd5, 80);
    run_phase(4'd15, 80);
    run_phase(4'd7, 80);
    run_phase(4'd2, 80);
    run_phase(4'd11, 80);
    run_phase(4'd9, 80);
    run_phase(4'd4, 80);
    run_phase(4'd10, 80);
    run_phase(4'd6, 80);
    run_phase(4'd8, 80);

    drain_results();
    if (sb.fails == 0) begin
      $display("[alternating_or_xor_reduction_tree] OK");
    end else begin
      $display("[alternating_or_xor_reduction_tree] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[alternating_or_xor_reduction_tree] ERROR");
    $finish;
  end

endmodule
